// ===== sv/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared constants and the signed sine lookup for the plasma pixel generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam int unsigned CoordWidth = 8;
    localparam int unsigned PixelWidth = 8;
    localparam int unsigned SineDepth  = 256;
    localparam int unsigned PipeDepth  = 5;

    // output bias that turns a signed sine into an unsigned level
    localparam logic [7:0] MidBias    = 8'h80;
    localparam logic [7:0] RowOffset  = 8'd128;
    localparam logic [9:0] SumOffset  = 10'd256;
    localparam logic [7:0] InvertMask = 8'hFF;

    typedef logic signed [7:0] sine_t;
    typedef logic [CoordWidth-1:0] coord_t;
    typedef logic [PixelWidth-1:0] pixel_t;

    // 256-entry signed sine, one period
    localparam sine_t SINE_ROM [SineDepth] = '{
        8'sd0, 8'sd3, 8'sd6, 8'sd9, 8'sd12, 8'sd15, 8'sd18, 8'sd21, 8'sd24, 8'sd28,
        8'sd31, 8'sd34, 8'sd37, 8'sd40, 8'sd43, 8'sd46, 8'sd48, 8'sd51, 8'sd54, 8'sd57,
        8'sd60, 8'sd63, 8'sd65, 8'sd68, 8'sd71, 8'sd73, 8'sd76, 8'sd78, 8'sd81, 8'sd83,
        8'sd85, 8'sd88, 8'sd90, 8'sd92, 8'sd94, 8'sd96, 8'sd98, 8'sd100, 8'sd102, 8'sd104,
        8'sd106, 8'sd108, 8'sd109, 8'sd111, 8'sd112, 8'sd114, 8'sd115, 8'sd116, 8'sd118,
        8'sd119, 8'sd120, 8'sd121, 8'sd122, 8'sd123, 8'sd124, 8'sd124, 8'sd125, 8'sd126,
        8'sd126, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127,
        8'sd127, 8'sd127, 8'sd126, 8'sd126, 8'sd125, 8'sd124, 8'sd124, 8'sd123, 8'sd122,
        8'sd121, 8'sd120, 8'sd119, 8'sd118, 8'sd117, 8'sd115, 8'sd114, 8'sd112, 8'sd111,
        8'sd109, 8'sd108, 8'sd106, 8'sd104, 8'sd102, 8'sd100, 8'sd99, 8'sd97, 8'sd94,
        8'sd92, 8'sd90, 8'sd88, 8'sd86, 8'sd83, 8'sd81, 8'sd78, 8'sd76, 8'sd73, 8'sd71,
        8'sd68, 8'sd65, 8'sd63, 8'sd60, 8'sd57, 8'sd54, 8'sd52, 8'sd49, 8'sd46, 8'sd43,
        8'sd40, 8'sd37, 8'sd34, 8'sd31, 8'sd28, 8'sd25, 8'sd22, 8'sd18, 8'sd15, 8'sd12,
        8'sd9, 8'sd6, 8'sd3,
        8'sd0, -8'sd2, -8'sd6, -8'sd9, -8'sd12, -8'sd15, -8'sd18, -8'sd21, -8'sd24,
        -8'sd27, -8'sd30, -8'sd33, -8'sd36, -8'sd39, -8'sd42, -8'sd45, -8'sd48, -8'sd51,
        -8'sd54, -8'sd57, -8'sd60, -8'sd62, -8'sd65, -8'sd68, -8'sd70, -8'sd73, -8'sd76,
        -8'sd78, -8'sd81, -8'sd83, -8'sd85, -8'sd88, -8'sd90, -8'sd92, -8'sd94, -8'sd96,
        -8'sd98, -8'sd100, -8'sd102, -8'sd104, -8'sd106, -8'sd107, -8'sd109, -8'sd111,
        -8'sd112, -8'sd114, -8'sd115, -8'sd116, -8'sd118, -8'sd119, -8'sd120, -8'sd121,
        -8'sd122, -8'sd123, -8'sd124, -8'sd124, -8'sd125, -8'sd126, -8'sd126, -8'sd127,
        -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd127,
        -8'sd127, -8'sd127, -8'sd126, -8'sd126, -8'sd125, -8'sd124, -8'sd124, -8'sd123,
        -8'sd122, -8'sd121, -8'sd120, -8'sd119, -8'sd118, -8'sd117, -8'sd115, -8'sd114,
        -8'sd113, -8'sd111, -8'sd109, -8'sd108, -8'sd106, -8'sd104, -8'sd103, -8'sd101,
        -8'sd99, -8'sd97, -8'sd95, -8'sd92, -8'sd90, -8'sd88, -8'sd86, -8'sd83, -8'sd81,
        -8'sd79, -8'sd76, -8'sd74, -8'sd71, -8'sd68, -8'sd66, -8'sd63, -8'sd60, -8'sd57,
        -8'sd55, -8'sd52, -8'sd49, -8'sd46, -8'sd43, -8'sd40, -8'sd37, -8'sd34, -8'sd31,
        -8'sd28, -8'sd25, -8'sd22, -8'sd19, -8'sd16, -8'sd12, -8'sd9, -8'sd6, -8'sd3,
        -8'sd3
    };

    function automatic sine_t sine_lookup(input logic [7:0] idx);
        sine_lookup = SINE_ROM[idx];
    endfunction

endpackage

// ===== sv/ppg_req_if.sv =====
// ----------------------------------------------------------------------------
// ppg_req_if
// Pixel request channel: coordinates, frame phase and foreground flag.
// ----------------------------------------------------------------------------
interface ppg_req_if;
    logic                valid;
    logic                ready;
    ppg_pkg::coord_t     column;
    ppg_pkg::coord_t     row;
    ppg_pkg::coord_t     frame;
    logic                is_foreground;

    modport source (output valid, column, row, frame, is_foreground, input ready);
    modport sink   (input valid, column, row, frame, is_foreground, output ready);
endinterface

// ===== sv/ppg_pix_if.sv =====
// ----------------------------------------------------------------------------
// ppg_pix_if
// Pixel result channel: one RGB332 byte per word.
// ----------------------------------------------------------------------------
interface ppg_pix_if;
    logic                valid;
    logic                ready;
    ppg_pkg::pixel_t     pixel;

    modport source (output valid, pixel, input ready);
    modport sink   (input valid, pixel, output ready);
endinterface

// ===== sv/plasma_pixel_generator_top.sv =====
// throughput: one word per cycle while the pixel sink keeps ready high
// the five-stage lookup pipeline stalls as a whole when the output word waits
// reset clears the stage valid bits only; no table fill or clearing pass
// the sine table is constant logic and is usable from the first cycle
// ----------------------------------------------------------------------------
// plasma_pixel_generator_top
// Plasma effect pixel generator: chained sine lookups to an RGB332 byte.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_top (
    input  logic     clk,
    input  logic     rst_n,
    ppg_req_if.sink  req,
    ppg_pix_if.source pix
);

    // stage valid bits, last one drives the output
    logic [ppg_pkg::PipeDepth-1:0] valid_reg;
    logic [ppg_pkg::PipeDepth-1:0] valid_next;
    logic                          advance;

    // stage 1: frame sine and column sine
    ppg_pkg::sine_t  s1_sfrm_reg, s1_scol_reg;
    ppg_pkg::coord_t s1_row_reg, s1_frm_reg;
    logic            s1_fg_reg;
    // stage 2: row sine
    ppg_pkg::sine_t  s2_p_reg, s2_scol_reg;
    ppg_pkg::coord_t s2_frm_reg;
    logic            s2_fg_reg;
    // stage 3: blended color index
    logic [7:0]      s3_color_reg;
    ppg_pkg::coord_t s3_frm_reg;
    logic            s3_fg_reg;
    // stage 4: channel sines
    ppg_pkg::sine_t  s4_r_reg, s4_g_reg, s4_b_reg;
    logic            s4_fg_reg;
    // stage 5: output byte
    ppg_pkg::pixel_t pix_reg;

    logic [7:0]      row_idx;
    logic [9:0]      blend_sum;
    logic [7:0]      color_idx;
    logic [7:0]      r_idx, g_idx, b_idx;
    logic [7:0]      red, green, blue;
    ppg_pkg::pixel_t packed_pix;

    // whole pipe moves unless the output word is held
    assign advance = !valid_reg[ppg_pkg::PipeDepth-1] || pix.ready;
    assign req.ready = advance;
    assign pix.valid = valid_reg[ppg_pkg::PipeDepth-1];
    assign pix.pixel = pix_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = {valid_reg[ppg_pkg::PipeDepth-2:0], req.valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // index arithmetic between stages
    assign row_idx   = s1_row_reg + ppg_pkg::RowOffset + s1_sfrm_reg;
    assign blend_sum = ppg_pkg::SumOffset + {{2{s2_scol_reg[7]}}, s2_scol_reg}
                       + {{2{s2_p_reg[7]}}, s2_p_reg};
    assign color_idx = blend_sum[8:1];
    assign r_idx     = s3_color_reg + s3_frm_reg;
    assign g_idx     = {s3_color_reg[4:0], 3'b000} - s3_color_reg + s3_frm_reg;
    assign b_idx     = {s3_color_reg[6:0], 1'b0} + s3_frm_reg;

    // bias by 128 flips the sign bit
    assign red   = s4_r_reg ^ ppg_pkg::MidBias;
    assign green = s4_g_reg ^ ppg_pkg::MidBias;
    assign blue  = s4_b_reg ^ ppg_pkg::MidBias;
    assign packed_pix = {red[7:5], green[7:5], blue[7:6]}
                        ^ (s4_fg_reg ? ppg_pkg::InvertMask : '0);

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sfrm_reg  <= ppg_pkg::sine_lookup(req.frame);
            s1_scol_reg  <= ppg_pkg::sine_lookup(req.column + req.frame);
            s1_row_reg   <= req.row;
            s1_frm_reg   <= req.frame;
            s1_fg_reg    <= req.is_foreground;

            s2_p_reg     <= ppg_pkg::sine_lookup(row_idx);
            s2_scol_reg  <= s1_scol_reg;
            s2_frm_reg   <= s1_frm_reg;
            s2_fg_reg    <= s1_fg_reg;

            s3_color_reg <= color_idx;
            s3_frm_reg   <= s2_frm_reg;
            s3_fg_reg    <= s2_fg_reg;

            s4_r_reg     <= ppg_pkg::sine_lookup(r_idx);
            s4_g_reg     <= ppg_pkg::sine_lookup(g_idx);
            s4_b_reg     <= ppg_pkg::sine_lookup(b_idx);
            s4_fg_reg    <= s3_fg_reg;

            pix_reg      <= packed_pix;
        end
    end

`ifndef SYNTHESIS
    // an accepted word always enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> valid_reg[0])
        else $error("accepted word lost at pipe entry");

    // a held output word blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && !pix.ready) |-> !req.ready)
        else $error("request taken while output stalled");

    // a word in the last inner stage reaches the output when the pipe moves
    a_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && valid_reg[ppg_pkg::PipeDepth-2]) |=> pix.valid)
        else $error("word dropped before output");

    // a stalled pipe keeps its occupancy
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("stage valid changed during stall");
`endif

endmodule
